// ----- sv/rfr_pkg.sv -----
// shared types and constants of the response frame recogniser
package rfr_pkg;

	localparam int unsigned MAX_FRAME = 128;
	localparam int unsigned LEN_W     = 8;
	localparam int unsigned POS_W     = 7;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [7:0] HDR_BYTE = 8'h93;
	localparam logic [7:0] ACK_BYTE = 8'hE5;
	localparam logic [7:0] ERR_MASK = 8'hF0;
	localparam logic [7:0] ERR_BASE = 8'hE0;

	localparam logic [7:0]       EXP_CMD_RST   = 8'd170;
	localparam logic [LEN_W-1:0] FRAME_LEN_RST = 8'd4;
	localparam logic [LEN_W-1:0] MIN_LEN       = 8'd3;
	localparam logic [LEN_W-1:0] MAX_LEN       = LEN_W'(MAX_FRAME);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_EXP_CMD   = 2'd0,
		REG_FRAME_LEN = 2'd1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_PEND     = 3'd0,
		ST_OK       = 3'd1,
		ST_BAD_XOR  = 3'd2,
		ST_DEV_ERR  = 3'd3,
		ST_ACK      = 3'd4
	} status_t;

	typedef enum logic [4:0] {
		PH_START   = 5'b00001,
		PH_HUNT    = 5'b00010,
		PH_HEADER  = 5'b00100,
		PH_COLLECT = 5'b01000,
		PH_DONE    = 5'b10000
	} phase_t;

	typedef struct packed {
		status_t          status;
		logic [7:0]       data_byte;
		logic             in_frame;
		logic [POS_W-1:0] position;
	} result_t;

endpackage

// ----- sv/rfr_byte_if.sv -----
// input channel: action and received byte
interface rfr_byte_if;
	import rfr_pkg::*;

	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] rx_byte;

	modport source (output valid, output action, output rx_byte, input ready);
	modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

// ----- sv/rfr_result_if.sv -----
// result channel: status, byte, frame flag and position
interface rfr_result_if;
	import rfr_pkg::*;

	logic             valid;
	logic             ready;
	status_t          status;
	logic [7:0]       data_byte;
	logic             in_frame;
	logic [POS_W-1:0] position;

	modport source (output valid, output status, output data_byte, output in_frame,
		output position, input ready);
	modport sink   (input valid, input status, input data_byte, input in_frame,
		input position, output ready);
endinterface

// ----- sv/rfr_cfg_if.sv -----
// configuration write channel: register index and data
interface rfr_cfg_if;
	import rfr_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [7:0]           data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- sv/response_frame_recognizer_core.sv -----
// response frame recogniser: byte-serial reply frame hunt and check
//
// byte_ch takes one word per cycle: a received byte, or a restart (action set)
// that begins a new response. Each word gives exactly one word on result_ch:
// status (pending, frame ok, checksum bad, device error, acknowledge), the byte,
// whether it belongs to the frame and its position from the header.
// cfg_ch writes expected_cmd (index 0) and frame_length (index 1); it is always
// ready and should be written only while the block is idle.
// The result word appears in the cycle after acceptance; throughput is one
// word per cycle, set by the single state update feeding the result register.
// byte_ch stays ready while the result register is empty or being taken, so a
// stalled receiver holds the result and stops intake until it is taken.
// After a terminal outcome further bytes pass as pending until a restart.
// Reset empties the result register, returns to the start of a response and
// loads expected_cmd 0xAA and frame_length 4.
module response_frame_recognizer_core (
	input logic           clk,
	input logic           arst_n,
	rfr_byte_if.sink      byte_ch,
	rfr_result_if.source  result_ch,
	rfr_cfg_if.sink       cfg_ch
);
	import rfr_pkg::*;

	logic [7:0]       exp_cmd_q;
	logic [LEN_W-1:0] frame_len_q;
	phase_t           phase_q, phase_d;
	logic [7:0]       xor_q, xor_d;
	logic [POS_W-1:0] cnt_q, cnt_d;
	logic             out_valid_q;
	result_t          res_q, res_d;

	logic             take;
	logic [LEN_W-1:0] len_eff;
	logic [7:0]       b;
	logic             is_hdr, is_ack, is_err, last_byte;

	assign cfg_ch.ready   = 1'b1;
	assign byte_ch.ready  = !out_valid_q || result_ch.ready;
	assign take           = byte_ch.valid && byte_ch.ready;

	assign b         = byte_ch.rx_byte;
	assign is_hdr    = (b == HDR_BYTE);
	assign is_ack    = (b == ACK_BYTE);
	assign is_err    = !is_ack && ((b & ERR_MASK) == ERR_BASE);
	assign len_eff   = (frame_len_q < MIN_LEN) ? MIN_LEN :
		(frame_len_q > MAX_LEN) ? MAX_LEN : frame_len_q;
	assign last_byte = ({1'b0, cnt_q} + LEN_W'(1)) >= len_eff;

	always_comb begin
		phase_d = phase_q;
		xor_d   = xor_q;
		cnt_d   = cnt_q;
		res_d   = '{status: ST_PEND, data_byte: b, in_frame: 1'b0, position: '0};
		if (byte_ch.action) begin
			phase_d         = PH_START;
			xor_d           = '0;
			cnt_d           = '0;
			res_d.data_byte = '0;
		end else begin
			case (phase_q)
				PH_START, PH_HUNT: begin
					if (phase_q == PH_START && is_err) begin
						phase_d      = PH_DONE;
						res_d.status = ST_DEV_ERR;
					end else if (is_hdr) begin
						phase_d        = PH_HEADER;
						xor_d          = b;
						cnt_d          = POS_W'(1);
						res_d.in_frame = 1'b1;
					end else if (is_ack) begin
						phase_d      = PH_DONE;
						res_d.status = ST_ACK;
					end else begin
						phase_d = PH_HUNT;
					end
				end
				PH_HEADER: begin
					if (b == exp_cmd_q) begin
						phase_d        = PH_COLLECT;
						xor_d          = HDR_BYTE ^ b;
						cnt_d          = POS_W'(2);
						res_d.in_frame = 1'b1;
						res_d.position = POS_W'(1);
					end else if (is_hdr) begin
						xor_d          = b;
						cnt_d          = POS_W'(1);
						res_d.in_frame = 1'b1;
					end else if (is_ack) begin
						phase_d      = PH_DONE;
						res_d.status = ST_ACK;
					end else begin
						phase_d = PH_HUNT;
						xor_d   = '0;
						cnt_d   = '0;
					end
				end
				PH_COLLECT: begin
					res_d.in_frame = 1'b1;
					res_d.position = cnt_q;
					if (last_byte) begin
						phase_d      = PH_DONE;
						res_d.status = (b == xor_q) ? ST_OK : ST_BAD_XOR;
					end else begin
						xor_d = xor_q ^ b;
						cnt_d = cnt_q + POS_W'(1);
					end
				end
				default: begin
					phase_d = PH_DONE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_cmd_q   <= EXP_CMD_RST;
			frame_len_q <= FRAME_LEN_RST;
		end else if (cfg_ch.valid) begin
			case (cfg_ch.index)
				REG_EXP_CMD:   exp_cmd_q   <= cfg_ch.data;
				REG_FRAME_LEN: frame_len_q <= cfg_ch.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_START;
			xor_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				phase_q <= phase_d;
				xor_q   <= xor_d;
				cnt_q   <= cnt_d;
			end
			if (take) begin
				out_valid_q <= 1'b1;
			end else if (result_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= res_d;
		end
	end

	assign result_ch.valid     = out_valid_q;
	assign result_ch.status    = res_q.status;
	assign result_ch.data_byte = res_q.data_byte;
	assign result_ch.in_frame  = res_q.in_frame;
	assign result_ch.position  = res_q.position;

`ifndef ASSERT_OFF
	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		take && byte_ch.action |=> result_ch.valid && result_ch.status == ST_PEND
		&& result_ch.data_byte == 8'h00 && phase_q == PH_START)
		else $error("restart word did not give an all-zero result");

	a_done_is_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		take && !byte_ch.action && phase_q == PH_DONE
		|=> result_ch.status == ST_PEND && !result_ch.in_frame)
		else $error("byte after terminal outcome was not passed as pending");

	a_terminal_phase: assert property (@(posedge clk) disable iff (!arst_n)
		result_ch.valid && result_ch.status != ST_PEND |-> phase_q == PH_DONE)
		else $error("terminal result without done phase");

	a_position_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		result_ch.valid && !result_ch.in_frame |-> result_ch.position == '0)
		else $error("position set outside a frame");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!result_ch.valid |-> byte_ch.ready)
		else $error("input stalled with empty result register");
`endif

endmodule
